[rtl/generational_handle_allocator_core_defines.svh]
// Assertion macros shared by the checker.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define GHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define GHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also runs during reset.
`define GHA_ASSERT_NEXT_ANY(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/gha_pkg.sv]
`default_nettype none

package gha_pkg;

   localparam int unsigned SLOTS_DEF        = 1024;
   localparam int unsigned GEN_BITS_DEF     = 16;
   localparam int unsigned CONTEXT_BITS_DEF = 8;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned STATUS_W = 2;

   localparam int unsigned LIMIT_W = 11;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [0:0]  REG_SLOT_LIMIT = 1'b0;

   localparam int unsigned RSP_FIFO_DEPTH = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 2'd0,
      CMD_DESTROY = 2'd1,
      CMD_CHECK   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SLOT  = 2'd1,
      STATUS_NULL     = 2'd2,
      STATUS_BAD_SLOT = 2'd3
   } status_type;

endpackage

`default_nettype wire

[rtl/gha_ram.sv]
`default_nettype none

module gha_ram #(
   parameter int unsigned WIDTH = gha_pkg::GEN_BITS_DEF,
   parameter int unsigned DEPTH = gha_pkg::SLOTS_DEF,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/gha_rsp_fifo.sv]
`default_nettype none

module gha_rsp_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = gha_pkg::RSP_FIFO_DEPTH,
   localparam int unsigned PTR_W = $clog2(DEPTH),
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  out_valid,
   output logic      [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[rtl/generational_handle_allocator_core.sv]
// Channel   Ports      Payload
// request   req_*      tuser: command; tdata: slot_index, generation, context_req
// response  rsp_*      tuser: status; tdata: slot_index_res, generation_res,
//                      context_res, is_valid, live_count
// csr       csr_*      slot_limit at byte address 0
//
// One request per cycle while tready is high; stages s1, s2, s3 feed the response FIFO.
// The rate is set by the generation table: one registered read and one write per cycle,
// with the previous cycle's write forwarded to the next read.
// tready drops while RSP_FIFO_DEPTH requests are outstanding.
// Reset clears counters, pipeline valids and the response queue; memories keep contents.
`default_nettype none

module generational_handle_allocator_core #(
   parameter int unsigned SLOTS        = gha_pkg::SLOTS_DEF,
   parameter int unsigned GEN_BITS     = gha_pkg::GEN_BITS_DEF,
   parameter int unsigned CONTEXT_BITS = gha_pkg::CONTEXT_BITS_DEF,
   localparam int unsigned IDX_W       = $clog2(SLOTS),
   localparam int unsigned CNT_W       = $clog2(SLOTS + 1),
   localparam int unsigned REQ_TDATA_W = ((IDX_W + GEN_BITS + CONTEXT_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_PAY_W   = IDX_W + GEN_BITS + CONTEXT_BITS + 1 + CNT_W,
   localparam int unsigned RSP_TDATA_W = ((RSP_PAY_W + 7) / 8) * 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // slot_index, generation, context_req
   input  wire logic [REQ_TDATA_W-1:0]           req_tdata,
   // command
   input  wire logic [gha_pkg::CMD_W-1:0]        req_tuser,

   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // slot_index_res, generation_res, context_res, is_valid, live_count
   output logic      [RSP_TDATA_W-1:0]           rsp_tdata,
   // status
   output logic      [gha_pkg::STATUS_W-1:0]     rsp_tuser,

   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [gha_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [gha_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [gha_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned LIM_CMP_W = (CNT_W > gha_pkg::LIMIT_W) ? CNT_W : gha_pkg::LIMIT_W;
   localparam int unsigned RES_W     = gha_pkg::STATUS_W + RSP_PAY_W;
   localparam int unsigned DEPTH     = gha_pkg::RSP_FIFO_DEPTH;
   localparam int unsigned OUT_W     = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      OP_FAIL,
      OP_POP,
      OP_FRESH,
      OP_BUMP,
      OP_CHECK
   } op_type;

   typedef struct packed {
      op_type                      op;
      gha_pkg::status_type         status;
      logic [IDX_W-1:0]            idx;
      logic [GEN_BITS-1:0]         gen;
      logic [CONTEXT_BITS-1:0]     ctx;
      logic [CNT_W-1:0]            live;
   } stage_type;

   logic accept;
   logic deliver;
   logic csr_wr;

   logic [gha_pkg::LIMIT_W-1:0] slot_limit_ff, slot_limit_in;
   logic [OUT_W-1:0]            outstanding_ff, outstanding_in;
   logic [CNT_W-1:0]            free_top_ff, free_top_in;
   logic [CNT_W-1:0]            slots_used_ff, slots_used_in;
   logic [CNT_W-1:0]            live_ff, live_in;

   logic                        s1_valid_ff, s1_valid_in;
   logic [gha_pkg::CMD_W-1:0]   s1_cmd_ff;
   logic [IDX_W-1:0]            s1_idx_ff;
   logic [GEN_BITS-1:0]         s1_gen_ff;
   logic [CONTEXT_BITS-1:0]     s1_ctx_ff;

   logic                        s2_valid_ff;
   stage_type                   s2_ff, s2_in;
   logic                        s3_valid_ff;
   stage_type                   s3_ff, s3_in;

   logic                        fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0]            fwd_addr_ff;
   logic [GEN_BITS-1:0]         fwd_data_ff;

   logic                        push;
   logic                        pop;
   logic [IDX_W-1:0]            stack_rdata;
   logic [IDX_W-1:0]            slot_s2;
   logic [GEN_BITS-1:0]         table_rdata;

   logic                        fresh_ok;
   logic                        idx_ok;
   logic                        is_null;

   logic [GEN_BITS-1:0]         gen_cur;
   logic [GEN_BITS-1:0]         gen_bump;
   logic [GEN_BITS-1:0]         res_gen;
   logic                        res_valid;
   logic                        tbl_wr;
   logic [RES_W-1:0]            fifo_in;
   logic [RES_W-1:0]            fifo_out;

   assign accept     = req_tvalid & req_tready;
   assign deliver    = rsp_tvalid & rsp_tready;
   assign req_tready = (outstanding_ff < OUT_W'(DEPTH));

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[gha_pkg::CSR_ADDR_W-1] == gha_pkg::REG_SLOT_LIMIT) ?
                       gha_pkg::CSR_DATA_W'(slot_limit_ff) : '0;

   always_comb begin
      slot_limit_in = slot_limit_ff;
      if (csr_wr && csr_paddr[gha_pkg::CSR_ADDR_W-1] == gha_pkg::REG_SLOT_LIMIT) begin
         slot_limit_in = csr_pwdata[gha_pkg::LIMIT_W-1:0];
      end
      case ({accept, deliver})
         2'b10:   outstanding_in = outstanding_ff + OUT_W'(1);
         2'b01:   outstanding_in = outstanding_ff - OUT_W'(1);
         default: outstanding_in = outstanding_ff;
      endcase
   end

   assign s1_valid_in = accept;

   assign fresh_ok = (LIM_CMP_W'(slots_used_ff) < LIM_CMP_W'(slot_limit_ff)) &&
                     (LIM_CMP_W'(slots_used_ff) < LIM_CMP_W'(SLOTS));
   assign idx_ok   = (CNT_W'(s1_idx_ff) < slots_used_ff);
   assign is_null  = (s1_idx_ff == '0) && (s1_gen_ff == '0) && (s1_ctx_ff == '0);

   always_comb begin
      free_top_in   = free_top_ff;
      slots_used_in = slots_used_ff;
      live_in       = live_ff;
      push          = 1'b0;
      pop           = 1'b0;
      s2_in.op      = OP_FAIL;
      s2_in.status  = gha_pkg::STATUS_OK;
      s2_in.idx     = s1_idx_ff;
      s2_in.gen     = s1_gen_ff;
      s2_in.ctx     = s1_ctx_ff;
      if (s1_valid_ff) begin
         case (s1_cmd_ff)
            gha_pkg::CMD_CREATE: begin
               if (free_top_ff != '0) begin
                  pop         = 1'b1;
                  free_top_in = free_top_ff - CNT_W'(1);
                  s2_in.op    = OP_POP;
               end else if (fresh_ok) begin
                  slots_used_in = slots_used_ff + CNT_W'(1);
                  s2_in.op      = OP_FRESH;
                  s2_in.idx     = slots_used_ff[IDX_W-1:0];
               end else begin
                  s2_in.status = gha_pkg::STATUS_NO_SLOT;
               end
               if (s2_in.op != OP_FAIL && live_ff != CNT_W'(SLOTS)) begin
                  live_in = live_ff + CNT_W'(1);
               end
            end
            gha_pkg::CMD_DESTROY: begin
               if (is_null) begin
                  s2_in.status = gha_pkg::STATUS_NULL;
               end else if (!idx_ok || free_top_ff == CNT_W'(SLOTS)) begin
                  s2_in.status = gha_pkg::STATUS_BAD_SLOT;
               end else begin
                  push        = 1'b1;
                  free_top_in = free_top_ff + CNT_W'(1);
                  s2_in.op    = OP_BUMP;
                  if (live_ff != '0) begin
                     live_in = live_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               if (!idx_ok) begin
                  s2_in.status = gha_pkg::STATUS_BAD_SLOT;
               end else begin
                  s2_in.op = OP_CHECK;
               end
            end
         endcase
      end
      s2_in.live = live_in;
   end

   gha_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SLOTS)
   ) u_free_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (free_top_ff[IDX_W-1:0]),
      .wr_data (s1_idx_ff),
      .rd_en   (pop),
      .rd_addr (free_top_in[IDX_W-1:0]),
      .rd_data (stack_rdata)
   );

   assign slot_s2 = (s2_ff.op == OP_POP) ? stack_rdata : s2_ff.idx;

   always_comb begin
      s3_in     = s2_ff;
      s3_in.idx = slot_s2;
   end

   gha_ram #(
      .WIDTH (GEN_BITS),
      .DEPTH (SLOTS)
   ) u_gen_table (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (s3_ff.idx),
      .wr_data (res_gen),
      .rd_en   (s2_valid_ff),
      .rd_addr (slot_s2),
      .rd_data (table_rdata)
   );

   assign gen_cur  = (fwd_valid_ff && fwd_addr_ff == s3_ff.idx) ? fwd_data_ff : table_rdata;
   assign gen_bump = (gen_cur + GEN_BITS'(1) == '0) ? GEN_BITS'(1) : gen_cur + GEN_BITS'(1);

   always_comb begin
      res_gen   = '0;
      res_valid = 1'b0;
      tbl_wr    = 1'b0;
      case (s3_ff.op)
         OP_POP: begin
            res_gen = gen_cur;
         end
         OP_FRESH: begin
            res_gen = GEN_BITS'(1);
            tbl_wr  = s3_valid_ff;
         end
         OP_BUMP: begin
            res_gen = gen_bump;
            tbl_wr  = s3_valid_ff;
         end
         OP_CHECK: begin
            res_gen   = gen_cur;
            res_valid = (gen_cur == s3_ff.gen);
         end
         default: begin
            res_gen = '0;
         end
      endcase
   end

   assign fwd_valid_in = tbl_wr;
   assign fifo_in      = {s3_ff.status, s3_ff.live, res_valid, s3_ff.ctx, res_gen, s3_ff.idx};

   gha_rsp_fifo #(
      .WIDTH (RES_W),
      .DEPTH (DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (fifo_in),
      .pop       (deliver),
      .out_valid (rsp_tvalid),
      .out_data  (fifo_out)
   );

   assign rsp_tuser = fifo_out[RES_W-1 -: gha_pkg::STATUS_W];
   assign rsp_tdata = RSP_TDATA_W'(fifo_out[RSP_PAY_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_limit_ff  <= gha_pkg::LIMIT_RESET;
         outstanding_ff <= '0;
         free_top_ff    <= '0;
         slots_used_ff  <= '0;
         live_ff        <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
      end else begin
         slot_limit_ff  <= slot_limit_in;
         outstanding_ff <= outstanding_in;
         free_top_ff    <= free_top_in;
         slots_used_ff  <= slots_used_in;
         live_ff        <= live_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         fwd_valid_ff   <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= req_tuser;
         s1_idx_ff <= req_tdata[IDX_W-1:0];
         s1_gen_ff <= req_tdata[IDX_W +: GEN_BITS];
         s1_ctx_ff <= req_tdata[IDX_W + GEN_BITS +: CONTEXT_BITS];
      end
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      fwd_addr_ff <= s3_ff.idx;
      fwd_data_ff <= res_gen;
   end

endmodule

`default_nettype wire

[rtl/gha_checker.sv]
`default_nettype none
`include "generational_handle_allocator_core_defines.svh"

module gha_checker #(
   parameter int unsigned SLOTS        = gha_pkg::SLOTS_DEF,
   parameter int unsigned GEN_BITS     = gha_pkg::GEN_BITS_DEF,
   parameter int unsigned CONTEXT_BITS = gha_pkg::CONTEXT_BITS_DEF,
   localparam int unsigned IDX_W       = $clog2(SLOTS),
   localparam int unsigned CNT_W       = $clog2(SLOTS + 1),
   localparam int unsigned RSP_PAY_W   = IDX_W + GEN_BITS + CONTEXT_BITS + 1 + CNT_W,
   localparam int unsigned RSP_TDATA_W = ((RSP_PAY_W + 7) / 8) * 8
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [RSP_TDATA_W-1:0]       rsp_tdata,
   input wire logic [gha_pkg::STATUS_W-1:0] rsp_tuser
);

   logic [GEN_BITS-1:0] rsp_gen;
   logic                rsp_is_valid;

   assign rsp_gen      = rsp_tdata[IDX_W +: GEN_BITS];
   assign rsp_is_valid = rsp_tdata[IDX_W + GEN_BITS + CONTEXT_BITS];

   `GHA_ASSERT_NEXT_ANY(a_reset_empty, clock, reset, !rsp_tvalid, "response after reset")
   `GHA_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `GHA_ASSERT_NOW(a_ok_gen, clock, reset, rsp_tvalid && rsp_tuser == gha_pkg::STATUS_OK, rsp_gen != '0, "zero generation on success")
   `GHA_ASSERT_NOW(a_fail_clean, clock, reset, rsp_tvalid && rsp_tuser != gha_pkg::STATUS_OK, rsp_gen == '0 && !rsp_is_valid, "failed request carries data")

endmodule

bind generational_handle_allocator_core gha_checker #(
   .SLOTS        (SLOTS),
   .GEN_BITS     (GEN_BITS),
   .CONTEXT_BITS (CONTEXT_BITS)
) u_gha_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[tb/sv/tb_generational_handle_allocator_core.sv]
`timescale 1ns / 100ps

module tb_generational_handle_allocator_core;

   localparam int unsigned SLOTS        = gha_pkg::SLOTS_DEF;
   localparam int unsigned IDX_W        = $clog2(SLOTS);
   localparam int unsigned GEN_W        = gha_pkg::GEN_BITS_DEF;
   localparam int unsigned CTX_W        = gha_pkg::CONTEXT_BITS_DEF;
   localparam int unsigned CNT_W        = $clog2(SLOTS + 1);
   localparam int unsigned CMD_W        = gha_pkg::CMD_W;
   localparam int unsigned STATUS_W     = gha_pkg::STATUS_W;
   localparam int unsigned CSR_ADDR_W   = gha_pkg::CSR_ADDR_W;
   localparam int unsigned CSR_DATA_W   = gha_pkg::CSR_DATA_W;
   localparam int unsigned LIMIT_W      = gha_pkg::LIMIT_W;
   localparam int unsigned REQ_W        = ((IDX_W + GEN_W + CTX_W + 7) / 8) * 8;
   localparam int unsigned RSP_W        = ((IDX_W + GEN_W + CTX_W + 1 + CNT_W + 7) / 8) * 8;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = {gha_pkg::REG_SLOT_LIMIT, 2'b00};
   localparam int unsigned HALF_PERIOD  = 4;
   localparam int unsigned RESET_CYCLES = 8;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned LONG_HOLD    = 100;
   localparam int unsigned CYCLE_LIMIT  = 100_000;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      logic [GEN_W-1:0] gen;
      logic [CTX_W-1:0] ctx;
   } handle_req_type;

   typedef struct {
      gha_pkg::status_type status;
      logic [IDX_W-1:0]    idx;
      logic [GEN_W-1:0]    gen;
      logic [CTX_W-1:0]    ctx;
      logic                valid;
      logic [CNT_W-1:0]    live;
   } handle_rsp_type;

   class handle_scoreboard;
      logic [GEN_W-1:0] gen_table [SLOTS];
      logic [IDX_W-1:0] free_stack [SLOTS];
      int unsigned      free_top;
      int unsigned      slots_used;
      int unsigned      live_total;
      int unsigned      slot_limit;
      handle_rsp_type   awaited [$];
      int unsigned      errors;
      int unsigned      requests;
      int unsigned      responses;
      int unsigned      deepest_stack;
      int unsigned      peak_live;
      int unsigned      wraps;

      function new();
         free_top      = 0;
         slots_used    = 0;
         live_total    = 0;
         slot_limit    = gha_pkg::LIMIT_RESET;
         errors        = 0;
         requests      = 0;
         responses     = 0;
         deepest_stack = 0;
         peak_live     = 0;
         wraps         = 0;
      endfunction

      function void mismatch(string field, longint unsigned want, longint unsigned got);
         $error("%s: expected %0d, actual %0d", field, want, got);
         errors++;
      endfunction

      function void note_request(handle_req_type r);
         handle_rsp_type   res;
         int unsigned      cap;
         logic [IDX_W-1:0] slot;
         logic [GEN_W-1:0] bumped;
         res.status = gha_pkg::STATUS_OK;
         res.idx    = r.idx;
         res.gen    = '0;
         res.ctx    = r.ctx;
         res.valid  = 1'b0;
         slot       = '0;
         requests++;
         if (r.cmd == gha_pkg::CMD_CREATE) begin
            cap = (slot_limit < SLOTS) ? slot_limit : SLOTS;
            if (free_top > 0) begin
               free_top--;
               slot = free_stack[free_top];
            end else if (slots_used < cap) begin
               slot = slots_used[IDX_W-1:0];
               gen_table[slot] = 1;
               slots_used++;
            end else begin
               res.status = gha_pkg::STATUS_NO_SLOT;
            end
            if (res.status == gha_pkg::STATUS_OK) begin
               if (live_total < SLOTS) live_total++;
               res.idx = slot;
               res.gen = gen_table[slot];
            end
         end else if (r.cmd == gha_pkg::CMD_DESTROY) begin
            if (r.idx == 0 && r.gen == 0 && r.ctx == 0) begin
               res.status = gha_pkg::STATUS_NULL;
            end else if (r.idx >= slots_used || free_top >= SLOTS) begin
               res.status = gha_pkg::STATUS_BAD_SLOT;
            end else begin
               bumped = gen_table[r.idx] + 1'b1;
               if (bumped == 0) begin
                  bumped = 1;
                  wraps++;
               end
               gen_table[r.idx] = bumped;
               if (live_total > 0) live_total--;
               free_stack[free_top] = r.idx;
               free_top++;
               res.gen = bumped;
            end
         end else if (r.idx >= slots_used) begin
            res.status = gha_pkg::STATUS_BAD_SLOT;
         end else begin
            res.gen   = gen_table[r.idx];
            res.valid = (gen_table[r.idx] == r.gen);
         end
         res.live = live_total[CNT_W-1:0];
         if (free_top > deepest_stack) deepest_stack = free_top;
         if (live_total > peak_live) peak_live = live_total;
         awaited = {awaited, res};
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [RSP_W-1:0] data);
         handle_rsp_type   want;
         logic [IDX_W-1:0] idx;
         logic [GEN_W-1:0] gen;
         logic [CTX_W-1:0] ctx;
         logic             valid;
         logic [CNT_W-1:0] live;
         responses++;
         if (awaited.size() == 0) begin
            $error("response with none awaited: status %0d, data 0x%0h", status, data);
            errors++;
            return;
         end
         want  = awaited.pop_front();
         idx   = data[IDX_W-1:0];
         gen   = data[IDX_W +: GEN_W];
         ctx   = data[IDX_W + GEN_W +: CTX_W];
         valid = data[IDX_W + GEN_W + CTX_W];
         live  = data[IDX_W + GEN_W + CTX_W + 1 +: CNT_W];
         if (status !== want.status) mismatch("status", want.status, status);
         if (idx !== want.idx) mismatch("slot_index_res", want.idx, idx);
         if (gen !== want.gen) mismatch("generation_res", want.gen, gen);
         if (ctx !== want.ctx) mismatch("context_res", want.ctx, ctx);
         if (valid !== want.valid) mismatch("is_valid", want.valid, valid);
         if (live !== want.live) mismatch("live_count", want.live, live);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // slot_index, generation, context_req
   logic [REQ_W-1:0]      req_tdata = '0;
   // command
   logic [CMD_W-1:0]      req_tuser = gha_pkg::CMD_CREATE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // slot_index_res, generation_res, context_res, is_valid, live_count
   logic [RSP_W-1:0]      rsp_tdata;
   // status
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   handle_scoreboard book = new();
   int unsigned      cycles = 0;
   int unsigned      limit_settings = 0;
   int unsigned      long_hold_asks = 0;
   int unsigned      long_hold_done = 0;
   int unsigned      hold_left = 0;
   bit               req_idle_on = 1'b1;
   bit               rsp_idle_on = 1'b1;

   generational_handle_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d responses still awaited", cycles,
                book.awaited.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) book.check_response(rsp_tuser, rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
         end else if (long_hold_asks != long_hold_done) begin
            long_hold_done++;
            hold_left = LONG_HOLD;
         end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 12);
         end
         rsp_tready <= (hold_left == 0);
      end
   end

   function automatic handle_req_type make_request(logic [CMD_W-1:0] cmd,
                                                   logic [IDX_W-1:0] idx,
                                                   logic [GEN_W-1:0] gen,
                                                   logic [CTX_W-1:0] ctx);
      handle_req_type r;
      r.cmd = cmd;
      r.idx = idx;
      r.gen = gen;
      r.ctx = ctx;
      return r;
   endfunction

   function automatic handle_req_type random_request();
      handle_req_type r;
      int unsigned    pick;
      int unsigned    sel;
      pick  = $urandom_range(0, 99);
      sel   = $urandom_range(0, 9);
      r.ctx = CTX_W'($urandom_range(0, 255));
      if (book.slots_used != 0 && $urandom_range(0, 9) < 8)
         r.idx = IDX_W'($urandom_range(0, book.slots_used - 1));
      else
         r.idx = IDX_W'($urandom_range(0, SLOTS - 1));
      if (r.idx < book.slots_used && sel < 6) begin
         r.gen = book.gen_table[r.idx];
      end else if (r.idx < book.slots_used && sel < 8) begin
         r.gen = (sel == 6) ? book.gen_table[r.idx] + 1'b1 : book.gen_table[r.idx] - 1'b1;
      end else begin
         r.gen = GEN_W'($urandom);
      end
      if (pick < 36) begin
         r.cmd = gha_pkg::CMD_CREATE;
      end else if (pick < 66) begin
         r.cmd = gha_pkg::CMD_DESTROY;
      end else if (pick < 95) begin
         r.cmd = gha_pkg::CMD_CHECK;
      end else if (pick < 98) begin
         r.cmd = CMD_RESERVED;
      end else begin
         r = make_request(gha_pkg::CMD_DESTROY, '0, '0, '0);
      end
      return r;
   endfunction

   task automatic send_request(handle_req_type r);
      int unsigned gap;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= REQ_W'({r.ctx, r.gen, r.idx});
      do @(posedge clock); while (!req_tready);
      book.note_request(r);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (book.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_slot_limit(logic [LIMIT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.slot_limit = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) book.mismatch("slot_limit", value, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      limit_settings++;
   endtask

   task automatic run_directed();
      send_request(make_request(gha_pkg::CMD_CHECK, '0, '0, '0));
      send_request(make_request(gha_pkg::CMD_DESTROY, '0, '0, '0));
      send_request(make_request(gha_pkg::CMD_DESTROY, 10'd5, 16'd1, 8'h00));
      send_request(make_request(gha_pkg::CMD_CREATE, 10'h3FF, 16'hFFFF, 8'hFF));
      send_request(make_request(gha_pkg::CMD_CREATE, '0, '0, '0));
      send_request(make_request(gha_pkg::CMD_CHECK, '0, 16'd1, 8'h01));
      send_request(make_request(gha_pkg::CMD_CHECK, '0, 16'hFFFF, 8'h80));
      send_request(make_request(CMD_RESERVED, 10'd1, 16'd1, 8'h7F));
      send_request(make_request(gha_pkg::CMD_DESTROY, '0, 16'hFFFF, 8'hA5));
      send_request(make_request(gha_pkg::CMD_DESTROY, '0, '0, 8'h01));
      send_request(make_request(gha_pkg::CMD_CHECK, '0, '0, '0));
      send_request(make_request(gha_pkg::CMD_CREATE, '0, '0, 8'h11));
      send_request(make_request(gha_pkg::CMD_CREATE, '0, '0, 8'h22));
      send_request(make_request(gha_pkg::CMD_CREATE, '0, '0, 8'h33));
      send_request(make_request(gha_pkg::CMD_CHECK, 10'd3, 16'd1, 8'h00));
      send_request(make_request(gha_pkg::CMD_CHECK, 10'd2, 16'd1, 8'h00));
      send_request(make_request(gha_pkg::CMD_DESTROY, 10'h3FF, '0, '0));
      send_request(make_request(gha_pkg::CMD_CHECK, 10'h3FF, 16'hFFFF, 8'hFF));
      settle();
      write_slot_limit(LIMIT_W'(book.slots_used));
      send_request(make_request(gha_pkg::CMD_CREATE, 10'h3FF, 16'h1234, 8'h5A));
      send_request(make_request(gha_pkg::CMD_DESTROY, 10'd1, 16'd1, 8'h0F));
      send_request(make_request(gha_pkg::CMD_CREATE, '0, '0, 8'hF0));
      send_request(make_request(gha_pkg::CMD_CREATE, 10'h155, 16'hAAAA, 8'h55));
      settle();
      write_slot_limit('0);
      send_request(make_request(gha_pkg::CMD_CREATE, 10'h2AA, 16'h5555, 8'hAA));
      settle();
   endtask

   task automatic run_mix(int unsigned count, bit with_hold);
      for (int unsigned i = 0; i < count; i++) begin
         if (with_hold && i == count / 2) long_hold_asks <= long_hold_asks + 1;
         send_request(random_request());
      end
      settle();
   endtask

   // Push stale handles until the free stack is full, try two more, check slot 0, then pop four.
   task automatic fill_free_stack();
      while (book.free_top < SLOTS)
         send_request(make_request(gha_pkg::CMD_DESTROY,
                                   IDX_W'($urandom_range(0, book.slots_used - 1)),
                                   GEN_W'($urandom), CTX_W'($urandom_range(1, 255))));
      repeat (2)
         send_request(make_request(gha_pkg::CMD_DESTROY,
                                   IDX_W'($urandom_range(0, book.slots_used - 1)),
                                   GEN_W'($urandom), CTX_W'($urandom_range(1, 255))));
      send_request(make_request(gha_pkg::CMD_CHECK, '0, book.gen_table[0], CTX_W'($urandom)));
      repeat (4)
         send_request(make_request(gha_pkg::CMD_CREATE, IDX_W'($urandom), GEN_W'($urandom),
                                   CTX_W'($urandom)));
      settle();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      write_slot_limit(11'd16);
      run_mix(100, 1'b1);
      write_slot_limit(11'h7FF);
      run_mix(40, 1'b0);
      write_slot_limit(11'd1);
      run_mix(30, 1'b0);
      write_slot_limit(11'd1024);
      fill_free_stack();
      write_slot_limit(11'd5);
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      run_mix(40, 1'b0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d requests and %0d responses over %0d slot_limit settings",
               book.requests, book.responses, limit_settings);
      $display("free stack peaked at %0d entries, live count at %0d, %0d generation wrap(s)",
               book.deepest_stack, book.peak_live, book.wraps);
      if (book.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
